// ----- rtl/mpsm_pkg.sv -----
// Package for the mass pair-sum match unit.
// Holds widths, codes, constants and the sequencer state type.
// No dependencies.
`default_nettype none
package mpsm_pkg;

	localparam int MAX_CAND_DEF = 64;

	localparam int ID_W    = 20;
	localparam int MASS_W  = 32;
	localparam int ROW_W   = 6;
	localparam int TOL_W   = 16;
	localparam int PPB_W   = 18;
	localparam int FUNC_W  = 2;

	localparam int MUL_W   = 32;
	localparam int PROD_W  = 64;
	localparam int LIM_W   = 48;
	localparam int PRODC_W = 52;
	localparam int CMP_W   = 60;
	localparam int DIVD_W  = 51;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [TOL_W-1:0]  TOL_RESET = 16'd2560;
	localparam logic [MUL_W-1:0]  ONE_E6    = 32'd1000000;
	localparam logic [MUL_W-1:0]  ONE_E9    = 32'd1000000000;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SCAN   = 2'd2;

	localparam logic REG_TOL = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD1,
		S_LIM,
		S_LIMW,
		S_RD2,
		S_DIFF,
		S_MULC,
		S_CMP,
		S_MULP,
		S_DIVL,
		S_DIV,
		S_PUSH,
		S_ADV,
		S_FLUSH
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/mpsm_mem.sv -----
// Candidate store: node ids and masses, one write and one registered read port.
// Depends on mpsm_pkg for field widths.
`default_nettype none
module mpsm_mem #(
	parameter int DEPTH = mpsm_pkg::MAX_CAND_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic [mpsm_pkg::ID_W-1:0]   wr_id,
	input  wire logic [mpsm_pkg::MASS_W-1:0] wr_mass,
	input  wire logic [AW-1:0]               rd_addr,
	output logic      [mpsm_pkg::ID_W-1:0]   rd_id,
	output logic      [mpsm_pkg::MASS_W-1:0] rd_mass
);

	logic [mpsm_pkg::ID_W-1:0]   id_mem   [DEPTH];
	logic [mpsm_pkg::MASS_W-1:0] mass_mem [DEPTH];
	logic [mpsm_pkg::ID_W-1:0]   rd_id_q;
	logic [mpsm_pkg::MASS_W-1:0] rd_mass_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[wr_addr]   <= wr_id;
			mass_mem[wr_addr] <= wr_mass;
		end
		rd_id_q   <= id_mem[rd_addr];
		rd_mass_q <= mass_mem[rd_addr];
	end

	assign rd_id   = rd_id_q;
	assign rd_mass = rd_mass_q;

endmodule
`default_nettype wire

// ----- rtl/mpsm_mul.sv -----
// Shared 32 by 32 multiplier with a registered product.
// Depends on mpsm_pkg for operand widths.
`default_nettype none
module mpsm_mul (
	input  wire logic                        clk,
	input  wire logic [mpsm_pkg::MUL_W-1:0]  op_a,
	input  wire logic [mpsm_pkg::MUL_W-1:0]  op_b,
	output logic      [mpsm_pkg::PROD_W-1:0] prod
);

	logic [mpsm_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= mpsm_pkg::PROD_W'(op_a) * mpsm_pkg::PROD_W'(op_b);
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

// ----- rtl/mpsm_div.sv -----
// Restoring divider giving one quotient bit per cycle.
// Depends on mpsm_pkg for dividend and quotient widths.
`default_nettype none
module mpsm_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [mpsm_pkg::DIVD_W-1:0] dividend,
	input  wire logic [mpsm_pkg::MASS_W-1:0] divisor,
	output logic                             done,
	output logic      [mpsm_pkg::PPB_W-1:0]  quot
);

	localparam int QW = mpsm_pkg::PPB_W;
	localparam int RW = mpsm_pkg::MASS_W;
	localparam int CNTW = $clog2(QW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [RW-1:0]   rem_q;
	logic [QW-1:0]   lo_q;
	logic [RW:0]     trial;
	logic            ge;
	logic [RW:0]     diff;

	assign trial = {rem_q, lo_q[QW-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[mpsm_pkg::DIVD_W-2:QW];
			lo_q  <= dividend[QW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
			lo_q  <= {lo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = lo_q;

endmodule
`default_nettype wire

// ----- rtl/mass_pair_sum_match_unit.sv -----
// Mass pair-sum match unit: clear and append complete when they are accepted.
// A scan of a stored row under a nonzero target steps through all N stored candidates,
// runs a divide for each of the H hits and can stall on the output; any other scan just flushes.
// The shared multiplier and one-bit-per-cycle divider serve the scan; one transaction is in work.
// Reset clears the count, target, partner, sequencer and output valid, and sets the
// tolerance to 2560; candidate memory contents stay undefined until written.
`default_nettype none
module mass_pair_sum_match_unit #(
	parameter int MAX_CANDIDATES = mpsm_pkg::MAX_CAND_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mpsm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [mpsm_pkg::PDATA_W-1:0]  pwdata,
	output logic      [mpsm_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mpsm_pkg::FUNC_W-1:0]   func,
	input  wire logic [mpsm_pkg::ID_W-1:0]     node_id,
	input  wire logic [mpsm_pkg::MASS_W-1:0]   mass,
	input  wire logic [mpsm_pkg::ID_W-1:0]     partner_in,
	input  wire logic [mpsm_pkg::ROW_W-1:0]    row,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               found,
	output logic      [mpsm_pkg::ID_W-1:0]     first_node,
	output logic      [mpsm_pkg::ID_W-1:0]     link_node,
	output logic      [mpsm_pkg::ID_W-1:0]     partner_out,
	output logic      [mpsm_pkg::PPB_W-1:0]    rel_diff_ppb,
	output logic                               last
);

	localparam int AW = $clog2(MAX_CANDIDATES);
	localparam int CW = $clog2(MAX_CANDIDATES + 1);
	localparam int RXW = mpsm_pkg::ROW_W + 1;
	localparam int IW = mpsm_pkg::ID_W;
	localparam int MW = mpsm_pkg::MASS_W;
	localparam int PW = mpsm_pkg::PPB_W;

	mpsm_pkg::state_t state_q, state_d;

	logic [mpsm_pkg::TOL_W-1:0] tol_q;
	logic [CW-1:0]              count_q;
	logic [MW-1:0]              target_q;
	logic [IW-1:0]              partner_q;
	logic [mpsm_pkg::ROW_W-1:0] row_q;
	logic [AW-1:0]              r2_q;
	logic [MW-1:0]              m1_q;
	logic [IW-1:0]              link_q;
	logic [IW-1:0]              id2_q;
	logic [mpsm_pkg::LIM_W-1:0] lim_q;
	logic [MW-1:0]              diff_q;
	logic                       big_q;

	logic          pend_valid_q;
	logic [IW-1:0] pend_first_q;
	logic [IW-1:0] pend_link_q;
	logic [PW-1:0] pend_ppb_q;

	logic          out_valid_q;
	logic          found_q;
	logic [IW-1:0] first_q;
	logic [IW-1:0] link_out_q;
	logic [IW-1:0] partner_out_q;
	logic [PW-1:0] ppb_q;
	logic          last_q;

	logic                          in_acc;
	logic                          cfg_wr;
	logic                          scan_ok;
	logic                          can_append;
	logic                          is_last_r2;
	logic                          hit;
	logic                          push_ok;
	logic                          flush_ok;
	logic [MW:0]                   sum;
	logic [MW:0]                   t_ext;
	logic [MW:0]                   absdiff;

	logic [AW-1:0]                 mem_raddr;
	logic                          mem_wen;
	logic [IW-1:0]                 mem_rid;
	logic [MW-1:0]                 mem_rmass;
	logic [mpsm_pkg::MUL_W-1:0]    mul_a;
	logic [mpsm_pkg::MUL_W-1:0]    mul_b;
	logic [mpsm_pkg::PROD_W-1:0]   mul_p;
	logic                          div_start;
	logic                          div_done;
	logic [PW-1:0]                 div_quot;

	mpsm_mem #(.DEPTH(MAX_CANDIDATES)) u_mem (
		.clk     (clk),
		.wr_en   (mem_wen),
		.wr_addr (count_q[AW-1:0]),
		.wr_id   (node_id),
		.wr_mass (mass),
		.rd_addr (mem_raddr),
		.rd_id   (mem_rid),
		.rd_mass (mem_rmass)
	);

	mpsm_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_p)
	);

	mpsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_p[mpsm_pkg::DIVD_W-1:0]),
		.divisor  (target_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[mpsm_pkg::PADDR_W-1] == mpsm_pkg::REG_TOL);
	assign prdata = (paddr[mpsm_pkg::PADDR_W-1] == mpsm_pkg::REG_TOL)
		? mpsm_pkg::PDATA_W'(tol_q) : '0;

	assign in_acc     = in_valid && in_ready;
	assign scan_ok    = (RXW'(row) < RXW'(count_q)) && (target_q != '0);
	assign can_append = count_q < CW'(MAX_CANDIDATES);
	assign is_last_r2 = (CW'(r2_q) + CW'(1)) == count_q;
	assign push_ok    = !pend_valid_q || !out_valid_q;
	assign flush_ok   = !out_valid_q;
	assign hit        = !big_q && ({mul_p[mpsm_pkg::PRODC_W-1:0], 8'h00}
		< mpsm_pkg::CMP_W'(lim_q));

	assign sum     = {1'b0, m1_q} + {1'b0, mem_rmass};
	assign t_ext   = {1'b0, target_q};
	assign absdiff = (sum >= t_ext) ? (sum - t_ext) : (t_ext - sum);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpsm_pkg::S_IDLE: begin
				if (in_valid && func == mpsm_pkg::FUNC_SCAN) begin
					state_d = scan_ok ? mpsm_pkg::S_RD1 : mpsm_pkg::S_FLUSH;
				end
			end
			mpsm_pkg::S_RD1:  state_d = mpsm_pkg::S_LIM;
			mpsm_pkg::S_LIM:  state_d = mpsm_pkg::S_LIMW;
			mpsm_pkg::S_LIMW: state_d = mpsm_pkg::S_RD2;
			mpsm_pkg::S_RD2:  state_d = mpsm_pkg::S_DIFF;
			mpsm_pkg::S_DIFF: state_d = mpsm_pkg::S_MULC;
			mpsm_pkg::S_MULC: state_d = mpsm_pkg::S_CMP;
			mpsm_pkg::S_CMP:  state_d = hit ? mpsm_pkg::S_MULP : mpsm_pkg::S_ADV;
			mpsm_pkg::S_MULP: state_d = mpsm_pkg::S_DIVL;
			mpsm_pkg::S_DIVL: state_d = mpsm_pkg::S_DIV;
			mpsm_pkg::S_DIV: begin
				if (div_done) begin
					state_d = mpsm_pkg::S_PUSH;
				end
			end
			mpsm_pkg::S_PUSH: begin
				if (push_ok) begin
					state_d = mpsm_pkg::S_ADV;
				end
			end
			mpsm_pkg::S_ADV: state_d = is_last_r2 ? mpsm_pkg::S_FLUSH : mpsm_pkg::S_RD2;
			mpsm_pkg::S_FLUSH: begin
				if (flush_ok) begin
					state_d = mpsm_pkg::S_IDLE;
				end
			end
			default: state_d = mpsm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == mpsm_pkg::S_IDLE);
		mem_raddr = (state_q == mpsm_pkg::S_RD1) ? row_q[AW-1:0] : r2_q;
		mem_wen   = in_acc && (func == mpsm_pkg::FUNC_APPEND) && can_append;
		div_start = (state_q == mpsm_pkg::S_DIVL);
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			mpsm_pkg::S_LIM: begin
				mul_a = mpsm_pkg::MUL_W'(tol_q);
				mul_b = target_q;
			end
			mpsm_pkg::S_MULC: begin
				mul_a = diff_q;
				mul_b = mpsm_pkg::ONE_E6;
			end
			mpsm_pkg::S_MULP: begin
				mul_a = diff_q;
				mul_b = mpsm_pkg::ONE_E9;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mpsm_pkg::S_IDLE;
			tol_q        <= mpsm_pkg::TOL_RESET;
			count_q      <= '0;
			target_q     <= '0;
			partner_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				tol_q <= pwdata[mpsm_pkg::TOL_W-1:0];
			end
			if (in_acc) begin
				priority case (func)
					mpsm_pkg::FUNC_CLEAR: begin
						count_q   <= '0;
						target_q  <= mass;
						partner_q <= partner_in;
					end
					mpsm_pkg::FUNC_APPEND: begin
						if (can_append) begin
							count_q <= count_q + CW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == mpsm_pkg::S_PUSH && push_ok) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == mpsm_pkg::S_FLUSH && flush_ok) begin
				pend_valid_q <= 1'b0;
			end
			if ((state_q == mpsm_pkg::S_PUSH && push_ok && pend_valid_q)
				|| (state_q == mpsm_pkg::S_FLUSH && flush_ok)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_q <= row;
		end
		if (state_q == mpsm_pkg::S_LIM) begin
			m1_q   <= mem_rmass;
			link_q <= mem_rid;
		end
		if (state_q == mpsm_pkg::S_LIMW) begin
			lim_q <= mul_p[mpsm_pkg::LIM_W-1:0];
			r2_q  <= '0;
		end
		if (state_q == mpsm_pkg::S_ADV) begin
			r2_q <= r2_q + AW'(1);
		end
		if (state_q == mpsm_pkg::S_DIFF) begin
			diff_q <= absdiff[MW-1:0];
			big_q  <= absdiff[MW];
			id2_q  <= mem_rid;
		end
		if (state_q == mpsm_pkg::S_PUSH && push_ok) begin
			if (pend_valid_q) begin
				found_q       <= 1'b1;
				first_q       <= pend_first_q;
				link_out_q    <= pend_link_q;
				partner_out_q <= partner_q;
				ppb_q         <= pend_ppb_q;
				last_q        <= 1'b0;
			end
			pend_first_q <= id2_q;
			pend_link_q  <= link_q;
			pend_ppb_q   <= div_quot;
		end
		if (state_q == mpsm_pkg::S_FLUSH && flush_ok) begin
			found_q       <= pend_valid_q;
			first_q       <= pend_valid_q ? pend_first_q : '0;
			link_out_q    <= pend_valid_q ? pend_link_q : '0;
			partner_out_q <= partner_q;
			ppb_q         <= pend_valid_q ? pend_ppb_q : '0;
			last_q        <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign first_node   = first_q;
	assign link_node    = link_out_q;
	assign partner_out  = partner_out_q;
	assign rel_diff_ppb = ppb_q;
	assign last         = last_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == mpsm_pkg::S_DIV)
		else $error("divider finished outside the divide state");

	a_flush_sets_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpsm_pkg::S_FLUSH && !out_valid_q) |=> (out_valid_q && last_q))
		else $error("final transaction of a scan not marked last");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_CANDIDATES))
		else $error("candidate count above capacity");

	a_miss_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> last_q)
		else $error("miss transaction not marked last");

endmodule
`default_nettype wire

// ----- bench/mass_pair_sum_match_unit_tb.sv -----
// Self-checking bench for mass_pair_sum_match_unit: clear, append and scan transactions
// with random idling, tolerance register writes between phases, and a result predictor.
// Depends on mpsm_pkg and the mass_pair_sum_match_unit RTL.

typedef struct {
	logic                         found;
	logic [mpsm_pkg::ID_W-1:0]    first_id;
	logic [mpsm_pkg::ID_W-1:0]    link_id;
	logic [mpsm_pkg::ID_W-1:0]    partner_id;
	logic [mpsm_pkg::PPB_W-1:0]   ppb;
	logic                         last_flag;
} pair_match_t;

class pair_sum_scoreboard;
	logic [mpsm_pkg::ID_W-1:0]   cand_id [mpsm_pkg::MAX_CAND_DEF];
	logic [mpsm_pkg::MASS_W-1:0] cand_mass [mpsm_pkg::MAX_CAND_DEF];
	int unsigned                 n_cand;
	logic [mpsm_pkg::MASS_W-1:0] target;
	logic [mpsm_pkg::ID_W-1:0]   partner;
	logic [mpsm_pkg::TOL_W-1:0]  tol;
	pair_match_t                 expected_matches[$];
	int                          errors;

	function new();
		n_cand = 0;
		target = '0;
		partner = '0;
		tol = mpsm_pkg::TOL_RESET;
		errors = 0;
	endfunction

	function void set_tolerance(logic [mpsm_pkg::TOL_W-1:0] v);
		tol = v;
	endfunction

	function int pending();
		return expected_matches.size();
	endfunction

	function void report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endfunction

	function void expect_match(pair_match_t m);
		expected_matches = {expected_matches, m};
	endfunction

	function void predict_scan(logic [mpsm_pkg::ROW_W-1:0] r);
		logic [63:0] t, sum, diff, lim, q;
		pair_match_t prev;
		bit have_prev;
		have_prev = 0;
		t = 64'(target);
		lim = 64'(tol) * t;
		if (r < n_cand && target != 0) begin
			for (int k = 0; k < n_cand; k++) begin
				sum = 64'(cand_mass[r]) + 64'(cand_mass[k]);
				diff = (sum >= t) ? sum - t : t - sum;
				if (diff * 64'd256000000 < lim) begin
					if (have_prev) begin
						expect_match(prev);
					end
					q = (diff * 64'd1000000000) / t;
					prev.found = 1'b1;
					prev.first_id = cand_id[k];
					prev.link_id = cand_id[r];
					prev.partner_id = partner;
					prev.ppb = q[mpsm_pkg::PPB_W-1:0];
					prev.last_flag = 1'b0;
					have_prev = 1;
				end
			end
		end
		if (!have_prev) begin
			prev.found = 1'b0;
			prev.first_id = '0;
			prev.link_id = '0;
			prev.partner_id = partner;
			prev.ppb = '0;
		end
		prev.last_flag = 1'b1;
		expect_match(prev);
	endfunction

	function void note_item(logic [mpsm_pkg::FUNC_W-1:0] f, logic [mpsm_pkg::ID_W-1:0] id,
			logic [mpsm_pkg::MASS_W-1:0] m, logic [mpsm_pkg::ID_W-1:0] p,
			logic [mpsm_pkg::ROW_W-1:0] r);
		case (f)
			mpsm_pkg::FUNC_CLEAR: begin
				n_cand = 0;
				target = m;
				partner = p;
			end
			mpsm_pkg::FUNC_APPEND: begin
				if (n_cand < mpsm_pkg::MAX_CAND_DEF) begin
					cand_id[n_cand] = id;
					cand_mass[n_cand] = m;
					n_cand++;
				end
			end
			mpsm_pkg::FUNC_SCAN: begin
				predict_scan(r);
			end
			default: ;
		endcase
	endfunction

	function void check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			report($sformatf("%s got %0h want %0h", name, got, want));
		end
	endfunction

	function void check_match(pair_match_t got);
		pair_match_t want;
		if (expected_matches.size() == 0) begin
			report($sformatf("unexpected result found=%0b first=%0h link=%0h",
				got.found, got.first_id, got.link_id));
			return;
		end
		want = expected_matches.pop_front();
		check_field("found", 32'(got.found), 32'(want.found));
		check_field("first_node", 32'(got.first_id), 32'(want.first_id));
		check_field("link_node", 32'(got.link_id), 32'(want.link_id));
		check_field("partner_out", 32'(got.partner_id), 32'(want.partner_id));
		check_field("rel_diff_ppb", 32'(got.ppb), 32'(want.ppb));
		check_field("last", 32'(got.last_flag), 32'(want.last_flag));
	endfunction
endclass

module mass_pair_sum_match_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASE_ITEMS = 28;
	localparam int SETTLE_CYCLES = 24;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam longint MASS_MAX = 64'h0000_0000_FFFF_FFFF;
	localparam logic [mpsm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic [mpsm_pkg::PADDR_W-1:0] TOL_ADDR = {mpsm_pkg::REG_TOL, 2'b00};

	logic                                clk;
	logic                                arst_n;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [mpsm_pkg::PADDR_W-1:0]        paddr;
	logic [mpsm_pkg::PDATA_W-1:0]        pwdata;
	logic [mpsm_pkg::PDATA_W-1:0]        prdata;
	logic                                pready;
	logic                                in_valid;
	logic                                in_ready;
	logic [mpsm_pkg::FUNC_W-1:0]         func;
	logic [mpsm_pkg::ID_W-1:0]           node_id;
	logic [mpsm_pkg::MASS_W-1:0]         mass;
	logic [mpsm_pkg::ID_W-1:0]           partner_in;
	logic [mpsm_pkg::ROW_W-1:0]          row;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic                                found;
	logic [mpsm_pkg::ID_W-1:0]           first_node;
	logic [mpsm_pkg::ID_W-1:0]           link_node;
	logic [mpsm_pkg::ID_W-1:0]           partner_out;
	logic [mpsm_pkg::PPB_W-1:0]          rel_diff_ppb;
	logic                                last;

	pair_sum_scoreboard sb = new();
	longint cycles = 0;
	int     items_sent = 0;
	int     stall_left = 0;
	bit     quiet = 1'b0;
	wire    calm = quiet || (cycles[9:8] == 2'b00);

	mass_pair_sum_match_unit DUT (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_monitor
		pair_match_t got;
		if (arst_n && out_valid && out_ready) begin
			got.found = found;
			got.first_id = first_node;
			got.link_id = link_node;
			got.partner_id = partner_out;
			got.ppb = rel_diff_ppb;
			got.last_flag = last;
			sb.check_match(got);
		end
	end

	task automatic send_item(logic [mpsm_pkg::FUNC_W-1:0] f, logic [mpsm_pkg::ID_W-1:0] id,
			logic [mpsm_pkg::MASS_W-1:0] m, logic [mpsm_pkg::ID_W-1:0] p,
			logic [mpsm_pkg::ROW_W-1:0] r);
		in_valid <= 1'b1;
		func <= f;
		node_id <= id;
		mass <= m;
		partner_in <= p;
		row <= r;
		do @(posedge clk); while (!in_ready);
		sb.note_item(f, id, m, p, r);
		if (f != FUNC_UNUSED) begin
			items_sent++;
		end
	endtask

	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [mpsm_pkg::TOL_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TOL_ADDR;
		pwdata <= mpsm_pkg::PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_tolerance(v);
	endtask

	function automatic logic [mpsm_pkg::MASS_W-1:0] pick_target();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return mpsm_pkg::MASS_W'($urandom_range(1, 1000));
			4, 5: return mpsm_pkg::MASS_W'($urandom_range(1, 32'h00FF_FFFF));
			default: return mpsm_pkg::MASS_W'($urandom);
		endcase
	endfunction

	// Picks a mass whose sum with m lands within about twice the tolerance window of t,
	// so that both hits and near misses occur.
	function automatic logic [mpsm_pkg::MASS_W-1:0] pair_mass(logic [mpsm_pkg::MASS_W-1:0] t,
			logic [mpsm_pkg::MASS_W-1:0] m);
		longint w, v;
		w = longint'(sb.tol) * longint'(t) / 256000000;
		v = longint'(t) - longint'(m) + longint'($urandom_range(0, 32'(4 * w + 2)))
			- (2 * w + 1);
		if (v < 0) begin
			v = 0;
		end
		if (v > MASS_MAX) begin
			v = MASS_MAX;
		end
		return v[31:0];
	endfunction

	task automatic run_group(bit fill);
		logic [mpsm_pkg::MASS_W-1:0] t, anchor, m;
		logic [mpsm_pkg::MASS_W-1:0] masses[$];
		int n, scans, top;
		t = pick_target();
		if (fill && t == 0) begin
			t = $urandom | 32'h8000_0000;
		end
		n = fill ? $urandom_range(65, 68) : $urandom_range(1, 10);
		send_item(mpsm_pkg::FUNC_CLEAR, mpsm_pkg::ID_W'($urandom), t,
			mpsm_pkg::ID_W'($urandom), mpsm_pkg::ROW_W'($urandom));
		maybe_gap();
		anchor = t >> 1;
		for (int k = 0; k < n; k++) begin
			if (fill) begin
				m = (k == 0) ? anchor : pair_mass(t, anchor);
			end else if (k == 0 || $urandom_range(0, 2) == 0) begin
				m = $urandom_range(t, 0);
			end else begin
				m = pair_mass(t, masses[$urandom_range(0, masses.size() - 1)]);
			end
			masses = {masses, m};
			send_item(mpsm_pkg::FUNC_APPEND, mpsm_pkg::ID_W'($urandom), m,
				mpsm_pkg::ID_W'($urandom), mpsm_pkg::ROW_W'($urandom));
			maybe_gap();
		end
		top = (n > mpsm_pkg::MAX_CAND_DEF) ? mpsm_pkg::MAX_CAND_DEF - 1 : n - 1;
		scans = $urandom_range(1, 4);
		for (int k = 0; k < scans; k++) begin
			send_item(mpsm_pkg::FUNC_SCAN, mpsm_pkg::ID_W'($urandom), $urandom,
				mpsm_pkg::ID_W'($urandom),
				mpsm_pkg::ROW_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, top)));
			maybe_gap();
		end
	endtask

	task automatic run_phase(bit fill);
		int stop;
		stop = items_sent + PHASE_ITEMS;
		if (fill) begin
			run_group(1'b1);
		end
		while (items_sent < stop) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(mpsm_pkg::FUNC_W'($urandom_range(0, 3)), mpsm_pkg::ID_W'($urandom),
					$urandom, mpsm_pkg::ID_W'($urandom), mpsm_pkg::ROW_W'($urandom));
				maybe_gap();
			end else begin
				run_group(1'b0);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		func <= mpsm_pkg::FUNC_CLEAR;
		node_id <= '0;
		mass <= '0;
		partner_in <= '0;
		row <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(mpsm_pkg::FUNC_SCAN, '0, '0, '0, '0);
		send_item(FUNC_UNUSED, '1, '1, '1, '1);
		send_item(mpsm_pkg::FUNC_CLEAR, '0, '0, '1, '0);
		send_item(mpsm_pkg::FUNC_APPEND, '1, 32'h8000_0000, '0, '0);
		send_item(mpsm_pkg::FUNC_APPEND, '0, 32'h8000_0000, '0, '0);
		send_item(mpsm_pkg::FUNC_SCAN, '0, '0, '0, '0);
		send_item(mpsm_pkg::FUNC_CLEAR, '0, 32'h3E80_0000, 20'd12345, '0);
		send_item(mpsm_pkg::FUNC_APPEND, 20'd1, 32'h1900_0000, '0, '0);
		send_item(mpsm_pkg::FUNC_APPEND, 20'd2, 32'h2580_0000, '0, '0);
		send_item(mpsm_pkg::FUNC_APPEND, 20'd3, 32'h2580_1388, '0, '0);
		send_item(mpsm_pkg::FUNC_APPEND, 20'd4, 32'h12C0_0000, '0, '0);
		send_item(mpsm_pkg::FUNC_SCAN, '0, '0, '0, 6'd0);
		send_item(mpsm_pkg::FUNC_SCAN, '0, '0, '0, 6'd1);
		send_item(mpsm_pkg::FUNC_SCAN, '0, '0, '0, 6'd63);
		send_item(mpsm_pkg::FUNC_SCAN, '0, '0, '0, 6'd3);
		send_item(mpsm_pkg::FUNC_CLEAR, '0, '1, '0, '0);
		send_item(mpsm_pkg::FUNC_APPEND, 20'd5, '1, '0, '0);
		send_item(mpsm_pkg::FUNC_APPEND, 20'd6, '0, '0, '0);
		send_item(mpsm_pkg::FUNC_SCAN, '0, '0, '0, 6'd0);
		send_item(mpsm_pkg::FUNC_SCAN, '0, '0, '0, 6'd1);
		// The second append sits exactly on the tolerance edge and must not match.
		send_item(mpsm_pkg::FUNC_CLEAR, '0, 32'd1000000, 20'hABCDE, '0);
		send_item(mpsm_pkg::FUNC_APPEND, 20'd7, 32'd500000, '0, '0);
		send_item(mpsm_pkg::FUNC_APPEND, 20'd8, 32'd500010, '0, '0);
		send_item(mpsm_pkg::FUNC_APPEND, 20'd9, 32'd500009, '0, '0);
		send_item(mpsm_pkg::FUNC_SCAN, '0, '0, '0, 6'd0);

		wait_idle();
		write_tolerance(16'hFFFF);
		run_phase(1'b1);
		wait_idle();
		write_tolerance(16'h0000);
		run_phase(1'b0);
		wait_idle();
		write_tolerance(16'h0001);
		run_phase(1'b0);
		wait_idle();
		write_tolerance(mpsm_pkg::TOL_W'($urandom_range(0, 65535)));
		run_phase(1'b0);
		wait_idle();
		quiet <= 1'b1;
		write_tolerance(mpsm_pkg::TOL_RESET);
		run_phase(1'b0);
		wait_idle();

		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- mass_pair_sum_match_unit.f -----
rtl/mpsm_pkg.sv
rtl/mpsm_mem.sv
rtl/mpsm_mul.sv
rtl/mpsm_div.sv
rtl/mass_pair_sum_match_unit.sv
bench/mass_pair_sum_match_unit_tb.sv
